>>> hdl/sfr_pkg.sv
// Shared constants and types for the sensor frame receiver.
package sfr_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PAYLOAD_W   = 2 * WORD_W;
  localparam int unsigned CNT_FIELD_W = 32;
  localparam int unsigned COUNTER_WIDTH_DEF = 32;

  localparam int unsigned FRAME_LEN = 16;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  localparam logic [DATA_W-1:0] HDR_FIRST  = 8'hAA;
  localparam logic [DATA_W-1:0] HDR_SECOND = 8'h55;
  localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA001;

  // Result codes.
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Control from the frame sequencer to the CRC unit.
  typedef struct packed {
    logic              init;
    logic              update;
    logic [DATA_W-1:0] data;
  } crc_ctl_t;

endpackage

>>> hdl/sfr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface sfr_in_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [SEQ_W-1:0]       sequence_res;
  logic [WORD_W-1:0]      angle_bits;
  logic [WORD_W-1:0]      rate_bits;
  logic [CNT_FIELD_W-1:0] good_count;
  logic [CNT_FIELD_W-1:0] bad_count;
  logic                   data_present;

  modport source (output valid, output status, output sequence_res, output angle_bits,
                  output rate_bits, output good_count, output bad_count,
                  output data_present, input ready);
  modport sink   (input valid, input status, input sequence_res, input angle_bits,
                  input rate_bits, input good_count, input bad_count,
                  input data_present, output ready);
endinterface

>>> hdl/sensor_frame_receiver_crc16_core.sv
// A frame's result is loaded into the result register when its 16th byte beat leaves the input stage.
// Throughput: one byte beat per cycle while no result stalls out_ch; the input stage and result register pipeline it.
// A result waiting on out_ch stalls only the byte in the input register behind it.
// Reset (synchronous, rst_n low): hunt for header, CRC to FFFF, counters and held
// sequence/payload to zero, no result pending.
module sensor_frame_receiver_crc16_core import sfr_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sfr_in_if.sink           in_ch,
  sfr_out_if.source        out_ch
);

  // Byte positions within the 16-byte frame.
  localparam logic [POS_W-1:0] POS_HUNT0    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HUNT1    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEQ_LO   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SEQ_HI   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PAY_LAST = POS_W'(11);
  localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(12);
  localparam logic [POS_W-1:0] POS_CRC_HI   = POS_W'(13);
  localparam logic [POS_W-1:0] POS_TRAILER  = POS_W'(14);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);
  localparam int unsigned      LANES        = PAYLOAD_W / DATA_W;
  localparam int unsigned      LANE_W       = $clog2(LANES);

  // Input stage: one registered byte beat.
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_byte_r;

  // Frame sequencer state.
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [CRC_W-1:0]     rx_crc_r, rx_crc_nxt;
  logic                 trailer_ok_r, trailer_ok_nxt;
  logic [SEQ_W-1:0]     stg_seq_r, stg_seq_nxt;
  logic [PAYLOAD_W-1:0] stg_pay_r, stg_pay_nxt;

  // Result register: status plus the held frame fields and counters.
  logic                     out_valid_r;
  logic                     status_r, status_nxt;
  logic [SEQ_W-1:0]         held_seq_r, held_seq_nxt;
  logic [PAYLOAD_W-1:0]     held_pay_r, held_pay_nxt;
  logic [COUNTER_WIDTH-1:0] good_cnt_r, good_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] bad_cnt_r, bad_cnt_nxt;
  logic                     seen_r, seen_nxt;

  logic             stall;
  logic             proc_fire;
  logic             in_fire;
  logic             out_load;
  logic             frame_ok;
  logic [LANE_W-1:0] lane;
  logic [CRC_W-1:0] crc_val;
  crc_ctl_t         crc_ctl;

  // Hold the byte in the input stage while an unread result blocks the output.
  assign stall     = out_valid_r && !out_ch.ready;
  assign proc_fire = s1_valid_r && !stall;
  assign in_ch.ready = !s1_valid_r || !stall;
  assign in_fire   = in_ch.valid && in_ch.ready;

  // Payload lane for positions 4..11: angle in lanes 0..3, rate in lanes 4..7.
  assign lane = LANE_W'(pos_r - (POS_SEQ_HI + POS_W'(1)));

  assign frame_ok = trailer_ok_r && (s1_byte_r == HDR_FIRST) && (crc_val == rx_crc_r);
  assign out_load = proc_fire && (pos_r == POS_LAST);

  // CRC covers frame bytes 2..11; restart it when the header completes.
  always_comb begin
    crc_ctl.init   = proc_fire && (pos_r == POS_HUNT1) && (s1_byte_r == HDR_SECOND);
    crc_ctl.update = proc_fire && (pos_r >= POS_SEQ_LO) && (pos_r <= POS_PAY_LAST);
    crc_ctl.data   = s1_byte_r;
  end

  sfr_crc16 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc_val)
  );

  // Frame sequencer: hunt header, stage fields, judge on the last byte.
  always_comb begin
    pos_nxt        = pos_r;
    rx_crc_nxt     = rx_crc_r;
    trailer_ok_nxt = trailer_ok_r;
    stg_seq_nxt    = stg_seq_r;
    stg_pay_nxt    = stg_pay_r;
    status_nxt     = status_r;
    held_seq_nxt   = held_seq_r;
    held_pay_nxt   = held_pay_r;
    good_cnt_nxt   = good_cnt_r;
    bad_cnt_nxt    = bad_cnt_r;
    seen_nxt       = seen_r;

    if (proc_fire) begin
      priority if (pos_r == POS_HUNT0) begin
        if (s1_byte_r == HDR_FIRST) pos_nxt = POS_HUNT1;
      end else if (pos_r == POS_HUNT1) begin
        // A repeated first header byte keeps the hunt alive.
        if (s1_byte_r == HDR_SECOND)     pos_nxt = POS_SEQ_LO;
        else if (s1_byte_r == HDR_FIRST) pos_nxt = POS_HUNT1;
        else                             pos_nxt = POS_HUNT0;
      end else if (pos_r == POS_LAST) begin
        pos_nxt = POS_HUNT0;
        if (frame_ok) begin
          status_nxt   = STATUS_GOOD;
          held_seq_nxt = stg_seq_r;
          held_pay_nxt = stg_pay_r;
          good_cnt_nxt = good_cnt_r + 1'b1;
          seen_nxt     = 1'b1;
        end else begin
          status_nxt  = STATUS_BAD;
          bad_cnt_nxt = bad_cnt_r + 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
        priority if (pos_r == POS_SEQ_LO) begin
          stg_seq_nxt[DATA_W-1:0] = s1_byte_r;
        end else if (pos_r == POS_SEQ_HI) begin
          stg_seq_nxt[SEQ_W-1:DATA_W] = s1_byte_r;
        end else if (pos_r <= POS_PAY_LAST) begin
          for (int i = 0; i < LANES; i++) begin
            if (lane == LANE_W'(i)) stg_pay_nxt[i*DATA_W +: DATA_W] = s1_byte_r;
          end
        end else if (pos_r == POS_CRC_LO) begin
          rx_crc_nxt[DATA_W-1:0] = s1_byte_r;
        end else if (pos_r == POS_CRC_HI) begin
          rx_crc_nxt[CRC_W-1:DATA_W] = s1_byte_r;
        end else if (pos_r == POS_TRAILER) begin
          trailer_ok_nxt = (s1_byte_r == HDR_SECOND);
        end else begin
          trailer_ok_nxt = trailer_ok_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pos_r        <= POS_HUNT0;
      trailer_ok_r <= 1'b0;
      out_valid_r  <= 1'b0;
      held_seq_r   <= '0;
      held_pay_r   <= '0;
      good_cnt_r   <= '0;
      bad_cnt_r    <= '0;
      seen_r       <= 1'b0;
    end else begin
      // Advance the input stage.
      if (in_fire)        s1_valid_r <= 1'b1;
      else if (proc_fire) s1_valid_r <= 1'b0;

      pos_r        <= pos_nxt;
      trailer_ok_r <= trailer_ok_nxt;
      held_seq_r   <= held_seq_nxt;
      held_pay_r   <= held_pay_nxt;
      good_cnt_r   <= good_cnt_nxt;
      bad_cnt_r    <= bad_cnt_nxt;
      seen_r       <= seen_nxt;

      // Present a result until it is taken; a new one may follow at once.
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Staged payload and status are always written before they are read.
  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_ch.rx_byte;
    rx_crc_r  <= rx_crc_nxt;
    stg_seq_r <= stg_seq_nxt;
    stg_pay_r <= stg_pay_nxt;
    status_r  <= status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.sequence_res = held_seq_r;
  assign out_ch.angle_bits   = held_pay_r[WORD_W-1:0];
  assign out_ch.rate_bits    = held_pay_r[PAYLOAD_W-1:WORD_W];
  assign out_ch.good_count   = CNT_FIELD_W'(good_cnt_r);
  assign out_ch.bad_count    = CNT_FIELD_W'(bad_cnt_r);
  assign out_ch.data_present = seen_r;

`ifndef SYNTH
  // Judging the last byte always returns the sequencer to the header hunt.
  a_judge_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && pos_r == POS_LAST) |=> (pos_r == POS_HUNT0))
    else $error("sequencer did not return to hunt after frame end");

  // Input back-pressure comes only from a blocked result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a pending result");

  // Once a frame has been accepted, data_present never drops.
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |=> seen_r)
    else $error("data_present dropped");

  // A good result bumps the good counter by one.
  a_good_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && frame_ok) |=> (good_cnt_r == $past(good_cnt_r) + 1'b1))
    else $error("good count did not advance on accepted frame");
`endif

endmodule

>>> hdl/sfr_crc16.sv
// Running CRC-16/MODBUS register with a one-byte-per-cycle update.
module sfr_crc16 import sfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  crc_ctl_t         ctl,
  output logic [CRC_W-1:0] crc
);

  logic [CRC_W-1:0] crc_r;

  // Reflected CRC, LSB first: eight shift/xor steps unrolled into one network.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] cur,
                                                input logic [DATA_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = cur ^ {{(CRC_W-DATA_W){1'b0}}, data};
    for (int k = 0; k < DATA_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else if (ctl.init) begin
      crc_r <= CRC_INIT;
    end else if (ctl.update) begin
      crc_r <= crc_byte(crc_r, ctl.data);
    end
  end

  assign crc = crc_r;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the CRC-16 framed sensor packet receiver core.
`timescale 1ns / 100ps

module tb_top;
  import sfr_pkg::*;

  // Run shape: idle odds per side (percent), the stretch of byte beats with no
  // idling, the long receiver hold-off and the safety limits.
  localparam int IDLE_PCT     = 6;
  localparam int QUIET_FROM   = 400;
  localparam int QUIET_TO     = 520;
  localparam int STALL_AT     = 250;
  localparam int STALL_CYCLES = 150;
  localparam int RAND_FRAMES  = 31;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 100000;

  // Ways a generated frame departs from a clean one.
  typedef enum int {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_DATA,
    FAULT_TRAILER,
    FAULT_SHORT
  } frame_fault_t;

  // One pending entry for the byte driver: a byte, or a marker that holds the
  // sender until every expected frame result has come back.
  typedef struct packed {
    logic              pause;
    logic [DATA_W-1:0] data;
  } rx_entry_t;

  // One frame verdict as the result channel reports it.
  typedef struct packed {
    logic                   status;
    logic [SEQ_W-1:0]       seq_no;
    logic [WORD_W-1:0]      angle;
    logic [WORD_W-1:0]      rate;
    logic [CNT_FIELD_W-1:0] good;
    logic [CNT_FIELD_W-1:0] bad;
    logic                   present;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  sensor_frame_receiver_crc16_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  rx_entry_t     rx_bytes_q[$];
  frame_result_t frame_results_q[$];

  int   beats_in = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic stall_done = 1'b0;
  logic byte_taken = 1'b0;
  logic quiet_stretch;

  assign quiet_stretch = (beats_in >= QUIET_FROM) && (beats_in < QUIET_TO);

  // Receiver mirror: frame position, CRC accumulator, staged and held fields.
  logic [POS_W-1:0]             rx_pos;
  logic [CRC_W-1:0]             crc_acc;
  logic [CRC_W-1:0]             crc_rx;
  logic                         tail_ok;
  logic [PAYLOAD_W-1:0]         stage_pl;
  logic [SEQ_W-1:0]             stage_seq;
  logic [SEQ_W-1:0]             held_seq;
  logic [PAYLOAD_W-1:0]         held_pl;
  logic [COUNTER_WIDTH_DEF-1:0] good_tot;
  logic [COUNTER_WIDTH_DEF-1:0] bad_tot;
  logic                         any_good;

  // CRC-16/MODBUS over one byte, LSB first.
  function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] acc,
                                                  input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    int k;
    c = acc ^ {8'h00, b};
    for (k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_frame_mirror();
    rx_pos    = '0;
    crc_acc   = CRC_INIT;
    crc_rx    = '0;
    tail_ok   = 1'b0;
    stage_pl  = '0;
    stage_seq = '0;
    held_seq  = '0;
    held_pl   = '0;
    good_tot  = '0;
    bad_tot   = '0;
    any_good  = 1'b0;
  endtask

  // Advance the mirror by one accepted byte; on the last frame byte, judge the
  // frame and queue the verdict the block must report.
  task automatic track_rx_byte(input logic [DATA_W-1:0] b);
    frame_result_t r;
    logic ok;
    if (rx_pos == 0) begin
      if (b == HDR_FIRST) rx_pos = POS_W'(1);
    end else if (rx_pos == 1) begin
      // A second AA keeps us waiting for 55; anything else restarts the hunt.
      if (b == HDR_SECOND) begin
        rx_pos  = POS_W'(2);
        crc_acc = CRC_INIT;
      end else begin
        rx_pos = (b == HDR_FIRST) ? POS_W'(1) : POS_W'(0);
      end
    end else begin
      // Inside a frame every byte is data, header patterns included.
      if (rx_pos <= 11) crc_acc = crc16_next(crc_acc, b);
      case (rx_pos)
        2:  stage_seq = {8'h00, b};
        3:  stage_seq[15:8] = b;
        12: crc_rx = {8'h00, b};
        13: crc_rx[15:8] = b;
        14: tail_ok = (b == HDR_SECOND);
        default: begin
          if (rx_pos <= 11) stage_pl[(int'(rx_pos) - 4) * 8 +: 8] = b;
        end
      endcase
      if (rx_pos == FRAME_LEN - 1) begin
        rx_pos = POS_W'(0);
        ok = tail_ok && (b == HDR_FIRST) && (crc_acc == crc_rx);
        if (ok) begin
          held_seq = stage_seq;
          held_pl  = stage_pl;
          good_tot = good_tot + 1'b1;
          any_good = 1'b1;
        end else begin
          // A rejected frame leaves the held fields as they were.
          bad_tot = bad_tot + 1'b1;
        end
        r.status  = ok ? STATUS_GOOD : STATUS_BAD;
        r.seq_no  = held_seq;
        r.angle   = held_pl[WORD_W-1:0];
        r.rate    = held_pl[PAYLOAD_W-1:WORD_W];
        r.good    = CNT_FIELD_W'(good_tot);
        r.bad     = CNT_FIELD_W'(bad_tot);
        r.present = any_good;
        frame_results_q.push_back(r);
      end else begin
        rx_pos = rx_pos + 1'b1;
      end
    end
  endtask

  task automatic queue_byte(input logic [DATA_W-1:0] b);
    rx_bytes_q.push_back('{pause: 1'b0, data: b});
  endtask

  task automatic queue_pause();
    rx_bytes_q.push_back('{pause: 1'b1, data: 8'h00});
  endtask

  // Build a full frame with a correct CRC and trailer, then damage it as asked.
  task automatic queue_frame(input logic [SEQ_W-1:0] seq, input logic [WORD_W-1:0] angle,
                             input logic [WORD_W-1:0] rate, input frame_fault_t fault);
    logic [DATA_W-1:0] frm [FRAME_LEN];
    logic [CRC_W-1:0]  crc;
    int k;
    int keep;
    frm[0] = HDR_FIRST;
    frm[1] = HDR_SECOND;
    frm[2] = seq[7:0];
    frm[3] = seq[15:8];
    for (k = 0; k < 4; k++) begin
      frm[4 + k] = angle[8 * k +: 8];
      frm[8 + k] = rate[8 * k +: 8];
    end
    crc = CRC_INIT;
    for (k = 2; k < 12; k++) crc = crc16_next(crc, frm[k]);
    frm[12] = crc[7:0];
    frm[13] = crc[15:8];
    frm[14] = HDR_SECOND;
    frm[15] = HDR_FIRST;
    keep = FRAME_LEN;
    case (fault)
      FAULT_CRC:     frm[12 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      FAULT_DATA:    frm[$urandom_range(11, 2)] ^= 8'(1 << $urandom_range(7));
      FAULT_TRAILER: frm[14 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
      FAULT_SHORT:   keep = $urandom_range(FRAME_LEN - 1, 3);
      default: ;
    endcase
    for (k = 0; k < keep; k++) queue_byte(frm[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Byte driver: drive at the falling edge, advance when no byte is offered or a beat
  // was taken at the previous rising edge, otherwise hold the offered byte.
  always @(negedge clk) begin : byte_driver
    rx_entry_t head;
    logic      hold_back;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      // Release a pause marker only once no frame verdict is outstanding.
      if (rx_bytes_q.size() > 0 && rx_bytes_q[0].pause && frame_results_q.size() == 0)
        rx_bytes_q.delete(0);
      hold_back = !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
      if (rx_bytes_q.size() > 0 && !rx_bytes_q[0].pause && !hold_back) begin
        head = rx_bytes_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= head.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Track accepted byte beats at the rising edge and update the mirror.
  always @(posedge clk) begin : byte_tracker
    byte_taken = rst_n && in_ch.valid && in_ch.ready;
    if (byte_taken) begin
      track_rx_byte(in_ch.rx_byte);
      beats_in++;
    end
  end

  // Result ready: random idling, plus one long hold-off while bytes keep
  // coming so the block backs up and stalls its input.
  always @(negedge clk) begin : result_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!stall_done && beats_in >= STALL_AT) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every result beat against the oldest expected verdict.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    frame_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status  = out_ch.status;
      got.seq_no  = out_ch.sequence_res;
      got.angle   = out_ch.angle_bits;
      got.rate    = out_ch.rate_bits;
      got.good    = out_ch.good_count;
      got.bad     = out_ch.bad_count;
      got.present = out_ch.data_present;
      results_seen++;
      if (frame_results_q.size() == 0) begin
        $display("%0t: result beat with no frame pending, expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("sequence_res", 32'(want.seq_no), 32'(got.seq_no));
        check_field("angle_bits", want.angle, got.angle);
        check_field("rate_bits", want.rate, got.rate);
        check_field("good_count", want.good, got.good);
        check_field("bad_count", want.bad, got.bad);
        check_field("data_present", 32'(want.present), 32'(got.present));
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int f;
    int pick;
    int n;
    logic [DATA_W-1:0] junk;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    clear_frame_mirror();

    // Directed: byte extremes while hunting, a header aborted by a foreign
    // byte, a repeated AA before 55, a rejected frame before any acceptance
    // whose sequence bytes look like a header, then a clean frame with extreme
    // field values.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(HDR_FIRST);
    queue_byte(8'h5A);
    queue_byte(HDR_FIRST);
    queue_frame({HDR_SECOND, HDR_FIRST}, $urandom, $urandom, FAULT_CRC);
    queue_frame(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, FAULT_NONE);
    queue_pause();

    // Random: mostly clean frames with random content, some damaged or cut
    // short, with noise and aborted headers between them.
    for (f = 0; f < RAND_FRAMES; f++) begin
      if ($urandom_range(99) < 15) begin
        for (n = $urandom_range(4, 1); n > 0; n--) queue_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 10) begin
        junk = 8'($urandom_range(255));
        if (junk == HDR_SECOND || junk == HDR_FIRST) junk ^= 8'h01;
        queue_byte(HDR_FIRST);
        queue_byte(junk);
      end
      pick = $urandom_range(99);
      queue_frame(16'($urandom), $urandom, $urandom,
                  (pick < 70) ? FAULT_NONE :
                  (pick < 78) ? FAULT_CRC :
                  (pick < 85) ? FAULT_DATA :
                  (pick < 93) ? FAULT_TRAILER : FAULT_SHORT);
      // Drain everything once mid-run before offering more bytes.
      if (f == RAND_FRAMES / 2) queue_pause();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be taken, then for the verdicts to drain.
    while (rx_bytes_q.size() != 0 || in_ch.valid) @(posedge clk);
    n = 0;
    while (frame_results_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      $display("%0t: %0d frame verdicts never arrived, expected 0 pending, actual %0d",
               $time, frame_results_q.size(), frame_results_q.size());
      errors += frame_results_q.size();
    end

    $display("Covered %0d byte beats and %0d frame verdicts (%0d accepted, %0d rejected),",
             beats_in, results_seen, good_tot, bad_tot);
    $display("with random idling, one long result hold-off and a full drain mid-run.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
